>>> rtl/rcpe_pkg.sv
// rcpe_pkg: shared types, constants and command tables of the remote command pulse encoder
// no dependencies, imported by rcpe_front, rcpe_back and remote_command_pulse_encoder
package rcpe_pkg;

  localparam int CTRL_W    = 27;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  typedef logic [4:0] step_t;

  localparam step_t STEP_LAST  = 5'd23;
  localparam step_t STEP_PLAY  = 5'd8;

  localparam logic [4:0] CODE_PLAY  = 5'h14;
  localparam logic [4:0] CODE_PAUSE = 5'h0a;
  localparam logic [4:0] CODE_ENTER = 5'h1a;
  localparam logic [7:0] CMD_TRAILER = 8'h20;
  localparam logic [2:0] CMD_PREFIX  = 3'b001;
  localparam logic [3:0] FRAME_PULSES = 4'd12;

  typedef enum logic [1:0] {
    FX_NONE  = 2'd0,
    FX_CLEAR = 2'd1,
    FX_SET   = 2'd2
  } fx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_TICKS    = 3'd0,
    CFG_ZERO_GAP_TICKS = 3'd1,
    CFG_ONE_GAP_TICKS  = 3'd2,
    CFG_IDLE_TICKS     = 3'd3,
    CFG_AUTOPLAY       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pulse_ticks;
    logic [7:0] zero_gap_ticks;
    logic [7:0] one_gap_ticks;
    logic [9:0] idle_ticks;
    logic       autoplay;
  } cfg_t;

  typedef struct packed {
    logic [CTRL_W-1:0] controls;
    logic              req_type;
  } item_t;

  // button bit examined at each scan step: functions, then digits, then enter
  function automatic logic [4:0] step_btn(step_t s);
    logic [4:0] b;
    if (s < 5'd13) begin
      b = s;
    end else if (s < 5'd23) begin
      b = s + 5'd3;
    end else begin
      b = 5'd26;
    end
    return b;
  endfunction

  function automatic logic [4:0] step_code(step_t s);
    logic [4:0] c;
    unique case (s)
      5'd0:  c = 5'h12;
      5'd1:  c = 5'h04;
      5'd2:  c = 5'h1c;
      5'd3:  c = 5'h08;
      5'd4:  c = 5'h02;
      5'd5:  c = 5'h18;
      5'd6:  c = 5'h0c;
      5'd7:  c = 5'h10;
      5'd8:  c = CODE_PLAY;
      5'd9:  c = 5'h0b;
      5'd10: c = 5'h06;
      5'd11: c = 5'h0e;
      5'd12: c = 5'h16;
      5'd13: c = 5'h01;
      5'd14: c = 5'h11;
      5'd15: c = 5'h09;
      5'd16: c = 5'h19;
      5'd17: c = 5'h05;
      5'd18: c = 5'h15;
      5'd19: c = 5'h0d;
      5'd20: c = 5'h1d;
      5'd21: c = 5'h03;
      5'd22: c = 5'h13;
      5'd23: c = CODE_ENTER;
      default: c = 5'h00;
    endcase
    return c;
  endfunction

  function automatic fx_t step_fx(step_t s);
    fx_t f;
    if (s == 5'd0 || s == 5'd1 || s == STEP_LAST) begin
      f = FX_CLEAR;
    end else if (s >= 5'd2 && s <= 5'd7) begin
      f = FX_SET;
    end else begin
      f = FX_NONE;
    end
    return f;
  endfunction

  // scan and fast buttons act on level
  function automatic logic step_level(step_t s);
    return (s == 5'd2) || (s == 5'd3) || (s == 5'd6) || (s == 5'd7);
  endfunction

endpackage

>>> rtl/rcpe_front.sv
// rcpe_front: input side, takes words, splits kind and controls, holds them in a two-entry queue
// depends on rcpe_pkg
module rcpe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rcpe_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [0:0]                    in_tuser,
  output rcpe_pkg::item_t               item,
  output logic                          item_valid,
  input  logic                          item_pop
);
  import rcpe_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready  = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{controls: in_tdata[CTRL_W-1:0], req_type: in_tuser[0]};
    end
  end

endmodule

>>> rtl/rcpe_back.sv
// rcpe_back: executes items, button scan with command byte queue and the pulse serializer
// depends on rcpe_pkg; fed by rcpe_front
module rcpe_back #(
  parameter int QUEUE_DEPTH = 16,
  localparam int QCW = $clog2(QUEUE_DEPTH + 1),
  localparam int IW  = $clog2(QUEUE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rcpe_pkg::cfg_t                  cfg,
  input  rcpe_pkg::item_t                 item,
  input  logic                            item_valid,
  output logic                            item_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rcpe_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [QCW-1:0]                  dbg_qcount,
  output logic [3:0]                      dbg_pulses_left,
  output logic                            dbg_push
);
  import rcpe_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_AUTO   = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_PUSH_A = 8'b0000_1000,
    ST_PUSH_B = 8'b0001_0000,
    ST_TICK   = 8'b0010_0000,
    ST_LOAD   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic              req_type_r, req_type_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [CTRL_W-1:0] prev_r, prev_nxt;
  logic              play_r, play_nxt;
  logic              auto_pend_r, auto_pend_nxt;
  logic              ret_auto_r, ret_auto_nxt;
  logic [4:0]        code_r, code_nxt;
  logic [4:0]        drop_r, drop_nxt;
  logic [IW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    qcount_r, qcount_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [3:0]        pl_r, pl_nxt;
  logic [9:0]        wait_r, wait_nxt;
  logic [7:0]        pcnt_r, pcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [7:0]        mem [QUEUE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic              room;
  logic [4:0]        bit_idx;
  logic              lvl, rise, trig, pnew;
  logic [4:0]        code_sel;
  fx_t               fx_sel;
  logic [9:0]        wdec, gap;
  logic [31:0]       q32;

  function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] p);
    return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room = ({1'b0, qcount_r} + (QCW+1)'(2)) <= (QCW+1)'(QUEUE_DEPTH);
  assign q32  = 32'(qcount_r);

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign dbg_qcount      = qcount_r;
  assign dbg_pulses_left = pl_r;
  assign dbg_push        = mem_we;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    req_type_nxt  = req_type_r;
    ctrl_nxt      = ctrl_r;
    prev_nxt      = prev_r;
    play_nxt      = play_r;
    auto_pend_nxt = auto_pend_r;
    ret_auto_nxt  = ret_auto_r;
    code_nxt      = code_r;
    drop_nxt      = drop_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    qcount_nxt    = qcount_r;
    shift_nxt     = shift_r;
    pl_nxt        = pl_r;
    wait_nxt      = wait_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    item_pop      = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = CMD_TRAILER;

    bit_idx  = step_btn(step_r);
    lvl      = ctrl_r[bit_idx];
    rise     = ctrl_r[bit_idx] && !prev_r[bit_idx];
    trig     = step_level(step_r) ? (lvl && (qcount_r <= QCW'(1))) : rise;
    pnew     = ~play_r;
    code_sel = step_code(step_r);
    fx_sel   = step_fx(step_r);
    wdec     = (wait_r != 10'd0) ? wait_r - 10'd1 : 10'd0;
    gap      = {2'b00, (shift_r[7] ? cfg.one_gap_ticks : cfg.zero_gap_ticks)};

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop     = 1'b1;
          req_type_nxt = item.req_type;
          ctrl_nxt     = item.controls;
          drop_nxt     = 5'd0;
          step_nxt     = '0;
          if (auto_pend_r) begin
            state_nxt = ST_AUTO;
          end else begin
            state_nxt = item.req_type ? ST_TICK : ST_SCAN;
          end
        end
      end
      ST_AUTO: begin
        auto_pend_nxt = 1'b0;
        state_nxt     = req_type_r ? ST_TICK : ST_SCAN;
        if (cfg.autoplay) begin
          if (room) begin
            code_nxt     = CODE_PLAY;
            play_nxt     = 1'b1;
            ret_auto_nxt = 1'b1;
            state_nxt    = ST_PUSH_A;
          end else begin
            drop_nxt = (drop_r != 5'd31) ? drop_r + 5'd1 : drop_r;
          end
        end
      end
      ST_SCAN: begin
        // play/pause flips the flag first, then picks play or pause
        if (step_r == STEP_PLAY && rise) begin
          play_nxt = pnew;
          code_sel = pnew ? CODE_PLAY : CODE_PAUSE;
        end
        if (trig && room) begin
          code_nxt     = code_sel;
          ret_auto_nxt = 1'b0;
          state_nxt    = ST_PUSH_A;
          if (fx_sel == FX_SET) begin
            play_nxt = 1'b1;
          end else if (fx_sel == FX_CLEAR) begin
            play_nxt = 1'b0;
          end
        end else begin
          if (trig) begin
            drop_nxt = (drop_r != 5'd31) ? drop_r + 5'd1 : drop_r;
          end
          if (step_r == STEP_LAST) begin
            prev_nxt  = ctrl_r;
            state_nxt = ST_DONE;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
      ST_PUSH_A: begin
        mem_we     = 1'b1;
        mem_wdata  = {CMD_PREFIX, code_r};
        wr_ptr_nxt = wrap_inc(wr_ptr_r);
        qcount_nxt = qcount_r + 1'b1;
        state_nxt  = ST_PUSH_B;
      end
      ST_PUSH_B: begin
        mem_we     = 1'b1;
        mem_wdata  = CMD_TRAILER;
        wr_ptr_nxt = wrap_inc(wr_ptr_r);
        qcount_nxt = qcount_r + 1'b1;
        if (ret_auto_r) begin
          state_nxt = req_type_r ? ST_TICK : ST_SCAN;
        end else if (step_r == STEP_LAST) begin
          prev_nxt  = ctrl_r;
          state_nxt = ST_DONE;
        end else begin
          step_nxt  = step_r + 5'd1;
          state_nxt = ST_SCAN;
        end
      end
      ST_TICK: begin
        state_nxt = ST_DONE;
        if (pcnt_r != 8'd0) begin
          pcnt_nxt = pcnt_r - 8'd1;
        end
        if (wdec != 10'd0) begin
          wait_nxt = wdec;
        end else if (pl_r != 4'd0) begin
          pcnt_nxt  = cfg.pulse_ticks;
          wait_nxt  = (gap == 10'd0) ? 10'd1 : gap;
          shift_nxt = {shift_r[6:0], 1'b0};
          pl_nxt    = pl_r - 4'd1;
        end else if (qcount_r != '0) begin
          // byte read is registered, taken in the next cycle
          rd_ptr_nxt = wrap_inc(rd_ptr_r);
          qcount_nxt = qcount_r - 1'b1;
          pl_nxt     = FRAME_PULSES;
          wait_nxt   = (cfg.idle_ticks == 10'd0) ? 10'd1 : cfg.idle_ticks;
          state_nxt  = ST_LOAD;
        end else begin
          wait_nxt = (cfg.idle_ticks == 10'd0) ? 10'd1 : cfg.idle_ticks;
        end
      end
      ST_LOAD: begin
        shift_nxt = rd_data_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, (pl_r != 4'd0), drop_r, q32[4:0], play_r,
                           (pcnt_r != 8'd0)};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      req_type_r  <= 1'b0;
      prev_r      <= '0;
      play_r      <= 1'b0;
      auto_pend_r <= 1'b1;
      ret_auto_r  <= 1'b0;
      drop_r      <= 5'd0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      qcount_r    <= '0;
      shift_r     <= 8'd0;
      pl_r        <= 4'd0;
      wait_r      <= 10'd1;
      pcnt_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      req_type_r  <= req_type_nxt;
      prev_r      <= prev_nxt;
      play_r      <= play_nxt;
      auto_pend_r <= auto_pend_nxt;
      ret_auto_r  <= ret_auto_nxt;
      drop_r      <= drop_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      qcount_r    <= qcount_nxt;
      shift_r     <= shift_nxt;
      pl_r        <= pl_nxt;
      wait_r      <= wait_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r     <= ctrl_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wdata;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

endmodule

>>> rtl/remote_command_pulse_encoder.sv
// remote_command_pulse_encoder: top level, config registers, front queue and back executor
// depends on rcpe_pkg, rcpe_front, rcpe_back
// the first word after reset also passes the autoplay step, which queues a play command
// when autoplay is set
// throughput: one word at a time in the back end, set by the serial 24-step button scan
// and the single write port of the byte queue; the front holds two more words meanwhile
// reset: rst_n synchronous active low, config to defaults, autoplay pending, queue empty
module remote_command_pulse_encoder #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rcpe_pkg::IN_DATA_W-1:0]   in_tdata,   // [26:0] controls, rest zero
  input  logic [0:0]                       in_tuser,   // [0] req_type: 0 sample, 1 tick
  // result words
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rcpe_pkg::OUT_DATA_W-1:0]  out_tdata,  // [0] control_line, [1] playing,
                                                       // [6:2] queue_level, [11:7] dropped,
                                                       // [12] sending, rest zero
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcpe_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cfg_t           cfg_r, cfg_nxt;
  item_t          item;
  logic           item_valid, item_pop;
  logic [QCW-1:0] dbg_qcount;
  logic [3:0]     dbg_pulses_left;
  logic           dbg_push;

  // registers always take a write
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PULSE_TICKS:    cfg_nxt.pulse_ticks    = cfg_data[7:0];
        CFG_ZERO_GAP_TICKS: cfg_nxt.zero_gap_ticks = cfg_data[7:0];
        CFG_ONE_GAP_TICKS:  cfg_nxt.one_gap_ticks  = cfg_data[7:0];
        CFG_IDLE_TICKS:     cfg_nxt.idle_ticks     = cfg_data[9:0];
        CFG_AUTOPLAY:       cfg_nxt.autoplay       = cfg_data[0];
        default:            cfg_nxt = cfg_r;  // unknown index is ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pulse_ticks: 8'd1, zero_gap_ticks: 8'd4, one_gap_ticks: 8'd8,
                 idle_ticks: 10'd120, autoplay: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accepts words and queues them in order, each with its kind
  rcpe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // back: button scan, command byte queue, pulse serializer, result register
  rcpe_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .item            (item),
    .item_valid      (item_valid),
    .item_pop        (item_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .dbg_qcount      (dbg_qcount),
    .dbg_pulses_left (dbg_pulses_left),
    .dbg_push        (dbg_push)
  );

`ifndef SYNTHESIS
  // byte queue never holds more than its depth
  a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dbg_qcount <= QCW'(QUEUE_DEPTH))
    else $error("byte queue count above depth");

  // a byte is only written when a slot is free
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    dbg_push |-> (dbg_qcount < QCW'(QUEUE_DEPTH)))
    else $error("byte written into full queue");

  // a frame never has more than twelve pulses
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    dbg_pulses_left <= FRAME_PULSES)
    else $error("pulse count beyond frame length");
`endif

endmodule
